/* rtl/block_buffer_cache_manager_macros.svh */
// Assertion macros for the block buffer cache manager
`ifndef BLOCK_BUFFER_CACHE_MANAGER_MACROS_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
`define BBCM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bbcm assertion failed");
`define BBCM_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("bbcm forbidden condition");
`else
`define BBCM_ASSERT(lbl, clk, rstn, prop)
`define BBCM_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/bbcm_pkg.sv */
// Shared constants, codes and control structs of the block buffer cache manager
package bbcm_pkg;
    localparam int SLOTS  = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int IN_W   = 64;
    localparam int OUT_W  = 48;

    localparam logic [2:0] CMD_GET        = 3'd0;
    localparam logic [2:0] CMD_FILL_DONE  = 3'd1;
    localparam logic [2:0] CMD_RELEASE    = 3'd2;
    localparam logic [2:0] CMD_MARK_DIRTY = 3'd3;
    localparam logic [2:0] CMD_WRITEBACK  = 3'd4;
    localparam logic [2:0] CMD_WRITE_DONE = 3'd5;
    localparam logic [2:0] CMD_SYNC       = 3'd6;
    localparam logic [2:0] CMD_NONE       = 3'd7;

    localparam logic [2:0] K_HIT    = 3'd0;
    localparam logic [2:0] K_READ   = 3'd1;
    localparam logic [2:0] K_WRITE  = 3'd2;
    localparam logic [2:0] K_NOFREE = 3'd3;
    localparam logic [2:0] K_BADDEV = 3'd4;
    localparam logic [2:0] K_ACK    = 3'd5;

    // word field sources
    localparam logic [2:0] SRC_ZERO = 3'd0;
    localparam logic [2:0] SRC_HIT  = 3'd1;
    localparam logic [2:0] SRC_VIC  = 3'd2;
    localparam logic [2:0] SRC_RD   = 3'd3;
    localparam logic [2:0] SRC_SCAN = 3'd4;
    localparam logic [2:0] SRC_SLOT = 3'd5;

    typedef struct packed {
        logic       load;
        logic       scan_clr;
        logic       scan_step;
        logic       rd_scan;
        logic       apply;
        logic       hit_upd;
        logic       vic_upd;
        logic       emit;
        logic [2:0] kind;
        logic [2:0] src;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] req_cmd;
        logic       bad;
        logic       oor;
        logic       slot_nw;
        logic       sync_any;
        logic       sync_hit;
        logic       sync_later;
        logic       scan_end;
        logic       hit_found;
        logic       vic_found;
        logic       vic_nw;
        logic       out_free;
    } dp_stat_t;
endpackage

/* rtl/bbcm_dp.sv */
// Datapath: entry table, recency ranks, scan trackers and output register
`include "block_buffer_cache_manager_macros.svh"
module bbcm_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bbcm_pkg::dp_cmd_t     cmd,
    output bbcm_pkg::dp_stat_t    stat,
    input  logic [bbcm_pkg::IN_W-1:0]  in_data,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata,
    output logic                  out_valid,
    output logic [bbcm_pkg::OUT_W-1:0] out_data,
    output logic                  out_last,
    input  logic                  out_ready
);
    import bbcm_pkg::*;

    logic [15:0]       bsize_cfg_reg;
    logic [2:0]        req_cmd_reg;
    logic [7:0]        req_dev_reg;
    logic [31:0]       req_blk_reg;
    logic [15:0]       req_bsize_reg;
    logic [3:0]        req_slot_reg;
    logic              req_ok_reg;

    logic [7:0]        dev_reg   [SLOTS];
    logic [31:0]       blk_reg   [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  dirty_reg;
    logic [15:0]       refs_reg  [SLOTS];
    logic [SLOT_W-1:0] rank_reg  [SLOTS];
    logic [SLOTS-1:0]  listed_reg;

    logic [SLOT_W-1:0] idx_reg;
    logic              hit_found_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic              vic_found_reg;
    logic [SLOT_W-1:0] vic_idx_reg;
    logic [SLOT_W-1:0] vic_rank_reg;
    logic [7:0]        vic_dev_reg;
    logic [31:0]       vic_blk_reg;
    logic              vic_nw_reg;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic [SLOT_W-1:0] slot_idx;
    logic [SLOT_W-1:0] rd_idx;
    logic [7:0]        rd_dev;
    logic [31:0]       rd_blk;
    logic              rd_nw;
    logic              scan_hit;
    logic              scan_vic;
    logic [SLOTS-1:0]  sync_vec;
    logic [SLOTS-1:0]  above_vec;
    logic              out_free;
    logic              mtf;
    logic [SLOT_W-1:0] mtf_idx;
    logic [3:0]        o_slot;
    logic [7:0]        o_dev;
    logic [31:0]       o_blk;

    assign slot_idx = SLOT_W'(req_slot_reg);
    assign rd_idx   = cmd.rd_scan ? idx_reg : slot_idx;
    assign rd_dev   = dev_reg[rd_idx];
    assign rd_blk   = blk_reg[rd_idx];
    assign rd_nw    = valid_reg[rd_idx] && dirty_reg[rd_idx] && (rd_dev != 8'd0);
    assign scan_hit = valid_reg[rd_idx] && (rd_dev == req_dev_reg) && (rd_blk == req_blk_reg);
    assign scan_vic = listed_reg[rd_idx] && (refs_reg[rd_idx] == 16'd0) &&
                      (!vic_found_reg || (rank_reg[rd_idx] < vic_rank_reg));
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            sync_vec[i]  = valid_reg[i] && dirty_reg[i] && (dev_reg[i] != 8'd0) &&
                           (dev_reg[i] == req_dev_reg);
            above_vec[i] = (SLOT_W'(i) > idx_reg);
        end
    end

    always_comb begin
        stat.req_cmd    = req_cmd_reg;
        stat.bad        = (req_dev_reg == 8'd0) || (req_bsize_reg != bsize_cfg_reg);
        stat.oor        = (32'(req_slot_reg) >= SLOTS);
        stat.slot_nw    = rd_nw;
        stat.sync_any   = |sync_vec;
        stat.sync_hit   = sync_vec[idx_reg];
        stat.sync_later = |(sync_vec & above_vec);
        stat.scan_end   = (idx_reg == SLOT_W'(SLOTS - 1));
        stat.hit_found  = hit_found_reg;
        stat.vic_found  = vic_found_reg;
        stat.vic_nw     = vic_nw_reg;
        stat.out_free   = out_free;
    end

    // entry update that moves a slot to the most recent end of the list
    always_comb begin
        mtf     = 1'b0;
        mtf_idx = slot_idx;
        if (cmd.apply) begin
            case (req_cmd_reg)
                CMD_FILL_DONE: mtf = !valid_reg[slot_idx] && (dev_reg[slot_idx] != 8'd0) &&
                                     !req_ok_reg;
                CMD_RELEASE:   mtf = (refs_reg[slot_idx] == 16'd1);
                default:       mtf = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsize_cfg_reg <= 16'd512;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            listed_reg    <= '1;
            for (int i = 0; i < SLOTS; i++) begin
                dev_reg[i]  <= 8'd0;
                blk_reg[i]  <= 32'd0;
                refs_reg[i] <= 16'd0;
                rank_reg[i] <= SLOT_W'(i);
            end
        end else begin
            if (cfg_we) begin
                bsize_cfg_reg <= cfg_wdata;
            end
            if (mtf) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (rank_reg[i] > rank_reg[mtf_idx]) begin
                        rank_reg[i] <= rank_reg[i] - SLOT_W'(1);
                    end
                end
                rank_reg[mtf_idx]   <= SLOT_W'(SLOTS - 1);
                listed_reg[mtf_idx] <= 1'b1;
            end
            if (cmd.apply) begin
                case (req_cmd_reg)
                    CMD_FILL_DONE: begin
                        if (!valid_reg[slot_idx] && dev_reg[slot_idx] != 8'd0) begin
                            if (req_ok_reg) begin
                                valid_reg[slot_idx] <= 1'b1;
                                dirty_reg[slot_idx] <= 1'b0;
                            end else begin
                                dev_reg[slot_idx]  <= 8'd0;
                                blk_reg[slot_idx]  <= 32'd0;
                                refs_reg[slot_idx] <= 16'd0;
                            end
                        end
                    end
                    CMD_RELEASE: begin
                        if (refs_reg[slot_idx] != 16'd0) begin
                            refs_reg[slot_idx] <= refs_reg[slot_idx] - 16'd1;
                        end
                    end
                    CMD_MARK_DIRTY: dirty_reg[slot_idx] <= 1'b1;
                    CMD_WRITE_DONE: begin
                        if (req_ok_reg) begin
                            dirty_reg[slot_idx] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.hit_upd) begin
                if (refs_reg[hit_idx_reg] != 16'hFFFF) begin
                    refs_reg[hit_idx_reg] <= refs_reg[hit_idx_reg] + 16'd1;
                end
                listed_reg[hit_idx_reg] <= 1'b0;
            end
            if (cmd.vic_upd) begin
                listed_reg[vic_idx_reg] <= 1'b0;
                dev_reg[vic_idx_reg]    <= req_dev_reg;
                blk_reg[vic_idx_reg]    <= req_blk_reg;
                refs_reg[vic_idx_reg]   <= 16'd1;
                valid_reg[vic_idx_reg]  <= 1'b0;
                dirty_reg[vic_idx_reg]  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_cmd_reg   <= in_data[2:0];
            req_dev_reg   <= in_data[10:3];
            req_blk_reg   <= in_data[42:11];
            req_bsize_reg <= in_data[58:43];
            req_slot_reg  <= in_data[62:59];
            req_ok_reg    <= in_data[63];
        end
        if (cmd.scan_step && scan_vic) begin
            vic_idx_reg  <= rd_idx;
            vic_rank_reg <= rank_reg[rd_idx];
            vic_dev_reg  <= rd_dev;
            vic_blk_reg  <= rd_blk;
            vic_nw_reg   <= rd_nw;
        end
        if (cmd.scan_step && scan_hit && !hit_found_reg) begin
            hit_idx_reg <= rd_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
        end else if (cmd.scan_clr) begin
            idx_reg       <= '0;
            hit_found_reg <= 1'b0;
            vic_found_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            idx_reg <= idx_reg + SLOT_W'(1);
            if (scan_hit) begin
                hit_found_reg <= 1'b1;
            end
            if (scan_vic) begin
                vic_found_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        o_slot = 4'd0;
        o_dev  = 8'd0;
        o_blk  = 32'd0;
        case (cmd.src)
            SRC_HIT: begin
                o_slot = 4'(hit_idx_reg);
                o_dev  = req_dev_reg;
                o_blk  = req_blk_reg;
            end
            SRC_VIC: begin
                o_slot = 4'(vic_idx_reg);
                o_dev  = vic_dev_reg;
                o_blk  = vic_blk_reg;
            end
            SRC_RD: begin
                o_slot = 4'(vic_idx_reg);
                o_dev  = req_dev_reg;
                o_blk  = req_blk_reg;
            end
            SRC_SCAN, SRC_SLOT: begin
                o_slot = 4'(rd_idx);
                o_dev  = rd_dev;
                o_blk  = rd_blk;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {1'b0, o_blk, o_dev, o_slot, cmd.kind};
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    `BBCM_NEVER(a_emit_full, aclk, aresetn, cmd.emit && !out_free)
    `BBCM_ASSERT(a_hit_upd, aclk, aresetn, cmd.hit_upd |-> hit_found_reg)
    `BBCM_ASSERT(a_vic_upd, aclk, aresetn, cmd.vic_upd |-> (vic_found_reg && !hit_found_reg))
    `BBCM_ASSERT(a_vic_claim, aclk, aresetn,
        cmd.vic_upd |=> (refs_reg[$past(vic_idx_reg)] == 16'd1 && !listed_reg[$past(vic_idx_reg)]))
endmodule

/* rtl/bbcm_ctrl.sv */
// Controller: command sequencing state machine
`include "block_buffer_cache_manager_macros.svh"
module bbcm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bbcm_pkg::dp_stat_t stat,
    output bbcm_pkg::dp_cmd_t  cmd
);
    import bbcm_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DEC       = 3'd1;
    localparam logic [2:0] S_SCAN_GET  = 3'd2;
    localparam logic [2:0] S_GET_DEC   = 3'd3;
    localparam logic [2:0] S_GET_RD    = 3'd4;
    localparam logic [2:0] S_SCAN_SYNC = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                cmd.last = 1'b1;
                cmd.kind = K_ACK;
                cmd.src  = SRC_ZERO;
                if (stat.req_cmd == CMD_GET) begin
                    if (stat.bad) begin
                        cmd.kind = K_BADDEV;
                        cmd.emit = stat.out_free;
                    end else begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN_GET;
                    end
                end else if (stat.req_cmd == CMD_SYNC) begin
                    if (!stat.sync_any) begin
                        cmd.emit = stat.out_free;
                    end else begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_SCAN_SYNC;
                    end
                end else if (stat.req_cmd == CMD_NONE || stat.oor) begin
                    cmd.emit = stat.out_free;
                end else if (stat.req_cmd == CMD_WRITEBACK && stat.slot_nw) begin
                    cmd.kind = K_WRITE;
                    cmd.src  = SRC_SLOT;
                    cmd.emit = stat.out_free;
                end else begin
                    cmd.emit  = stat.out_free;
                    cmd.apply = stat.out_free;
                end
                if (cmd.emit) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_GET: begin
                cmd.rd_scan   = 1'b1;
                cmd.scan_step = 1'b1;
                if (stat.scan_end) begin
                    state_next = S_GET_DEC;
                end
            end
            S_GET_DEC: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                    if (stat.hit_found) begin
                        cmd.kind    = K_HIT;
                        cmd.src     = SRC_HIT;
                        cmd.hit_upd = 1'b1;
                    end else if (!stat.vic_found) begin
                        cmd.kind = K_NOFREE;
                        cmd.src  = SRC_ZERO;
                    end else if (stat.vic_nw) begin
                        cmd.kind   = K_WRITE;
                        cmd.src    = SRC_VIC;
                        cmd.last   = 1'b0;
                        state_next = S_GET_RD;
                    end else begin
                        cmd.kind    = K_READ;
                        cmd.src     = SRC_RD;
                        cmd.vic_upd = 1'b1;
                    end
                end
            end
            S_GET_RD: begin
                cmd.kind = K_READ;
                cmd.src  = SRC_RD;
                cmd.last = 1'b1;
                if (stat.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.vic_upd = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN_SYNC: begin
                cmd.rd_scan = 1'b1;
                cmd.kind    = K_WRITE;
                cmd.src     = SRC_SCAN;
                cmd.last    = !stat.sync_later;
                if (stat.sync_hit) begin
                    if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.scan_step = 1'b1;
                        if (!stat.sync_later) begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `BBCM_NEVER(a_ready_busy, aclk, aresetn, in_ready && state_reg != S_IDLE)
    `BBCM_ASSERT(a_accept_dec, aclk, aresetn, (in_valid && in_ready) |=> state_reg == S_DEC)
    `BBCM_NEVER(a_state_legal, aclk, aresetn, state_reg > S_SCAN_SYNC)
endmodule

/* rtl/block_buffer_cache_manager.sv */
// Top level of the block buffer cache manager: controller plus datapath
//
//  channel  | dir | payload
//  s_       | in  | command, device, block_number, bsize, slot, ok (tdata)
//  m_       | out | kind, out_slot, out_device, out_block (tdata), last (tlast)
//  cfg_     | in  | expected_bsize
//
// One word at a time. A get scans all 16 entries, one per cycle; sync scans
// until its last write request. Reset is immediate, no clearing pass.
// A stalled m_ side holds the scan where the next word waits.
module block_buffer_cache_manager (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0] device[10:3] block_number[42:11] bsize[58:43] slot[62:59] ok[63]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // kind[2:0] out_slot[6:3] out_device[14:7] out_block[46:15] zero[47]
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import bbcm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bbcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bbcm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );
endmodule

/* tb/tb_block_buffer_cache_manager.sv */
// Testbench for the block buffer cache manager: directed and random commands vs a predictor
module tb_block_buffer_cache_manager;
    import bbcm_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  oslot;
        logic [7:0]  odev;
        logic [31:0] oblk;
        logic        last;
    } cache_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    logic [15:0] bsize_reg;
    logic [7:0]  p_dev [SLOTS];
    logic [31:0] p_blk [SLOTS];
    logic        p_valid [SLOTS];
    logic        p_dirty [SLOTS];
    logic [15:0] p_refs [SLOTS];
    int          p_rank [SLOTS];
    logic        p_listed [SLOTS];

    cache_word_t expected_words[$];
    int          err_count;
    int          cycle_count;
    int          hold_off;
    int          stall_max;
    logic [31:0] blk_pool [8];

    block_buffer_cache_manager uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    function automatic void push_word(logic [2:0] k, int s, logic [7:0] d, logic [31:0] b);
        cache_word_t w;
        w.kind = k; w.oslot = s[3:0]; w.odev = d; w.oblk = b; w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void bump_recent(int s);
        for (int i = 0; i < SLOTS; i++)
            if (p_rank[i] > p_rank[s]) p_rank[i]--;
        p_rank[s] = SLOTS - 1;
        p_listed[s] = 1'b1;
    endfunction

    function automatic logic writable(int s);
        return p_valid[s] && p_dirty[s] && p_dev[s] != 8'd0;
    endfunction

    function automatic void predict_command(logic [2:0] cmd, logic [7:0] dev, logic [31:0] blk,
                                            logic [15:0] bsz, logic [3:0] slot, logic ok);
        int n0;
        int victim;
        int s;
        cache_word_t w;
        n0 = expected_words.size();
        s = slot;
        victim = -1;
        if (cmd == CMD_GET) begin
            if (dev == 8'd0 || bsz != bsize_reg) begin
                push_word(K_BADDEV, 0, 8'd0, 32'd0);
            end else begin
                for (int i = 0; i < SLOTS && victim < 0; i++)
                    if (p_valid[i] && p_dev[i] == dev && p_blk[i] == blk) victim = i + 100;
                if (victim >= 100) begin
                    victim -= 100;
                    if (p_refs[victim] != 16'hFFFF) p_refs[victim]++;
                    p_listed[victim] = 1'b0;
                    push_word(K_HIT, victim, dev, blk);
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (p_listed[i] && p_refs[i] == 16'd0 &&
                            (victim < 0 || p_rank[i] < p_rank[victim])) victim = i;
                    if (victim < 0) begin
                        push_word(K_NOFREE, 0, 8'd0, 32'd0);
                    end else begin
                        p_listed[victim] = 1'b0;
                        if (writable(victim))
                            push_word(K_WRITE, victim, p_dev[victim], p_blk[victim]);
                        p_dev[victim] = dev;
                        p_blk[victim] = blk;
                        p_refs[victim] = 16'd1;
                        p_valid[victim] = 1'b0;
                        p_dirty[victim] = 1'b0;
                        push_word(K_READ, victim, dev, blk);
                    end
                end
            end
        end else if (cmd == CMD_SYNC) begin
            for (int i = 0; i < SLOTS; i++)
                if (p_dev[i] == dev && writable(i)) push_word(K_WRITE, i, p_dev[i], p_blk[i]);
            if (expected_words.size() == n0) push_word(K_ACK, 0, 8'd0, 32'd0);
        end else if (cmd == CMD_NONE || s >= SLOTS) begin
            push_word(K_ACK, 0, 8'd0, 32'd0);
        end else if (cmd == CMD_WRITEBACK && writable(s)) begin
            push_word(K_WRITE, s, p_dev[s], p_blk[s]);
        end else begin
            case (cmd)
                CMD_FILL_DONE: begin
                    if (!p_valid[s] && p_dev[s] != 8'd0) begin
                        if (ok) begin
                            p_valid[s] = 1'b1;
                            p_dirty[s] = 1'b0;
                        end else begin
                            p_dev[s] = 8'd0; p_blk[s] = 32'd0; p_refs[s] = 16'd0;
                            bump_recent(s);
                        end
                    end
                end
                CMD_RELEASE: begin
                    if (p_refs[s] != 16'd0) begin
                        p_refs[s]--;
                        if (p_refs[s] == 16'd0) bump_recent(s);
                    end
                end
                CMD_MARK_DIRTY: p_dirty[s] = 1'b1;
                CMD_WRITE_DONE: if (ok) p_dirty[s] = 1'b0;
                default: ;
            endcase
            push_word(K_ACK, 0, 8'd0, 32'd0);
        end
        w = expected_words[$];
        w.last = 1'b1;
        expected_words[$] = w;
    endfunction

    // valid stays high after an accept; a gap before the next word or a drain takes it down
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] dev, input logic [31:0] blk,
                             input logic [15:0] bsz, input logic [3:0] slot, input logic ok);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {ok, slot, bsz, blk, dev, cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(cmd, dev, blk, bsz, slot, ok);
    endtask

    task automatic drain_and_wait();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_bsize_cfg(input logic [15:0] v);
        drain_and_wait();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        bsize_reg = v;
    endtask

    task automatic get_block(input logic [7:0] dev, input logic [31:0] blk);
        send_word(CMD_GET, dev, blk, bsize_reg, 4'd0, 1'b0);
    endtask

    task automatic test_directed();
        get_block(8'd0, 32'd5);
        send_word(CMD_GET, 8'd1, 32'd5, 16'd511, 4'd0, 1'b0);
        get_block(8'd1, 32'hFFFFFFFF);
        get_block(8'hFF, 32'd0);
        send_word(CMD_FILL_DONE, 8'd0, 32'd0, 16'd0, 4'd0, 1'b1);
        send_word(CMD_FILL_DONE, 8'd0, 32'd0, 16'd0, 4'd1, 1'b0);
        get_block(8'd1, 32'hFFFFFFFF);
        get_block(8'd1, 32'hFFFFFFFF);
        send_word(CMD_MARK_DIRTY, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_WRITEBACK, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_MARK_DIRTY, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_WRITE_DONE, 8'd0, 32'd0, 16'd0, 4'd0, 1'b1);
        send_word(CMD_WRITEBACK, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_MARK_DIRTY, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_WRITE_DONE, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_SYNC, 8'd1, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_SYNC, 8'd9, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_RELEASE, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_RELEASE, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_RELEASE, 8'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_word(CMD_RELEASE, 8'd0, 32'd0, 16'd0, 4'd15, 1'b1);
        send_word(CMD_NONE, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 4'd15, 1'b1);
        get_block(8'd2, 32'd0);
        get_block(8'd2, 32'd0);
    endtask

    // fills every slot with referenced entries, then misses with nothing free
    task automatic test_no_free_slot();
        for (int i = 0; i < SLOTS + 1; i++) get_block(8'd3, 32'd1000 + i);
        for (int i = 0; i < SLOTS; i++)
            send_word(CMD_FILL_DONE, 8'd0, 32'd0, 16'd0, i[3:0], 1'b1);
        for (int i = 0; i < SLOTS; i++)
            send_word(CMD_MARK_DIRTY, 8'd0, 32'd0, 16'd0, i[3:0], 1'b0);
        send_word(CMD_SYNC, 8'd3, 32'd0, 16'd0, 4'd0, 1'b0);
        for (int i = 0; i < SLOTS; i++)
            send_word(CMD_RELEASE, 8'd0, 32'd0, 16'd0, i[3:0], 1'b0);
    endtask

    task automatic test_saturation();
        drain_and_wait();
        for (int i = 0; i < SLOTS; i++) p_refs[i] = p_refs[i];
        // repeated gets of one entry; the count stays far from 65535 so only the
        // increment below saturation is exercised here
        get_block(8'd4, 32'd77);
        for (int i = 0; i < 4; i++) get_block(8'd4, 32'd77);
    endtask

    task automatic send_random_item();
        logic [2:0]  cmd;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [15:0] bsz;
        int          r;
        r = $urandom_range(0, 99);
        dev = 8'(1 + $urandom_range(0, 3));
        blk = blk_pool[$urandom_range(0, 7)];
        bsz = bsize_reg;
        if (r < 40) cmd = CMD_GET;
        else if (r < 55) cmd = CMD_FILL_DONE;
        else if (r < 70) cmd = CMD_RELEASE;
        else if (r < 78) cmd = CMD_MARK_DIRTY;
        else if (r < 84) cmd = CMD_WRITEBACK;
        else if (r < 90) cmd = CMD_WRITE_DONE;
        else if (r < 96) cmd = CMD_SYNC;
        else cmd = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 19) == 0) begin
            dev = 8'($urandom);
            blk = $urandom;
            bsz = 16'($urandom);
        end
        send_word(cmd, dev, blk, bsz, 4'($urandom_range(0, 15)), $urandom_range(0, 5) != 0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) send_random_item();
    endtask

    // receiver stops for a long stretch while commands keep coming
    task automatic test_backpressure();
        drain_and_wait();
        hold_off = 400;
        for (int i = 0; i < 12; i++) get_block(8'd5, 32'd200 + i);
        hold_off = 0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", m_tdata, 48'd0);
            end else begin
                cache_word_t w;
                w = expected_words.pop_front();
                if (m_tdata[2:0] != w.kind)
                    report("kind", 48'(m_tdata[2:0]), 48'(w.kind));
                if (m_tdata[6:3] != w.oslot)
                    report("out_slot", 48'(m_tdata[6:3]), 48'(w.oslot));
                if (m_tdata[14:7] != w.odev)
                    report("out_device", 48'(m_tdata[14:7]), 48'(w.odev));
                if (m_tdata[46:15] != w.oblk)
                    report("out_block", 48'(m_tdata[46:15]), 48'(w.oblk));
                if (m_tdata[47] != 1'b0)
                    report("pad", 48'(m_tdata[47]), 48'd0);
                if (m_tlast != w.last)
                    report("last", 48'(m_tlast), 48'(w.last));
            end
        end
    end

    initial begin
        int wait_left;
        m_tready = 1'b0;
        wait_left = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                hold_off--;
            end else if (m_tready && m_tvalid) begin
                wait_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, stall_max);
                m_tready <= (wait_left == 0);
            end else if (wait_left > 0) begin
                wait_left--;
                m_tready <= (wait_left == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        err_count = 0;
        hold_off = 0;
        stall_max = 6;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        bsize_reg = 16'd512;
        for (int i = 0; i < SLOTS; i++) begin
            p_dev[i] = 8'd0; p_blk[i] = 32'd0; p_valid[i] = 1'b0; p_dirty[i] = 1'b0;
            p_refs[i] = 16'd0; p_rank[i] = i; p_listed[i] = 1'b1;
        end
        for (int i = 0; i < 8; i++) blk_pool[i] = $urandom;
        blk_pool[0] = 32'd0;
        blk_pool[1] = 32'hFFFFFFFF;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_no_free_slot();
        test_saturation();
        test_backpressure();
        test_random(80);
        write_bsize_cfg(16'd1);
        test_random(55);
        write_bsize_cfg(16'hFFFF);
        test_random(55);
        write_bsize_cfg(16'd512);
        test_random(30);
        drain_and_wait();

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
